[src/hmnm_pkg.sv]
// Shared package for the height map to normal map block.
// Holds register codes, reset values, queue word types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package hmnm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_STRENGTH = 2'd2;

  localparam logic [10:0] WIDTH_RST    = 11'd1024;
  localparam logic [15:0] HEIGHT_RST   = 16'd1024;
  localparam logic [15:0] STRENGTH_RST = 16'd4096;

  // (127 * 4096)^2, the squared numerator of z
  localparam logic [63:0] Z_NUM_SQ = 64'd520192 * 64'd520192;
  // one, squared, in Q24
  localparam logic [47:0] Q_BIAS   = 48'h100_0000;

  typedef struct packed {
    logic [7:0] center;
    logic [7:0] right;
    logic [7:0] below;
    logic       last;
    logic       frame_done;
  } job_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
    logic       frame_done;
  } res_t;

endpackage

[src/heightmap_to_normal_map.sv]
// Top level of the height map to normal map block.
// Depends on hmnm_pkg, hmnm_fifo, hmnm_front and hmnm_back.
`timescale 1ns / 1ps

// Usage
//   Input: heights in raster order. A word is taken on a clock edge with
//   in_push high and in_full low. After a word is taken, in_full stays
//   high through the second line store read, the hand-off of each job
//   (zero to three) to the job queue, and the return to idle.
//   Output: normal words, oldest first, on out_* while out_empty is low;
//   out_pop takes one. Each job passes through the back end in order:
//   it takes the job, runs three multiply stages and seven trial steps of
//   the square-root search, then offers the result until the result queue
//   has room. It takes no new job before then, so the back end sets the
//   sustained rate, with up to three jobs per height on the last row.
//   Rows are returned one row late; the last row one pixel late, its final pixel at once.
//   last_in_run marks the final word caused by one height, frame_done the
//   word of the frame's final pixel.
//   Configuration: cfg_we writes cfg_data to register cfg_index (width,
//   height, strength); write only while idle.
//   Reset clears counters, queues and control state. The line store is
//   not cleared: the first row never reads it.
//   A stalled reader fills the result queue, then the back end holds,
//   the job queue fills, and finally in_full stays high.
module heightmap_to_normal_map #(
  parameter int MAX_WIDTH = hmnm_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_height_value,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_blue_value,
  output logic [7:0]  out_green_value,
  output logic [7:0]  out_red_value,
  output logic        out_last_in_run,
  output logic        out_frame_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int JOB_W = $bits(hmnm_pkg::job_t);
  localparam int RES_W = $bits(hmnm_pkg::res_t);

  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [15:0] strength_r;

  hmnm_pkg::job_t front_job, back_job;
  hmnm_pkg::res_t back_res, out_res;
  logic           jq_push, jq_full, jq_pop, jq_empty;
  logic           rq_push, rq_full;

  // register file; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= hmnm_pkg::WIDTH_RST;
      height_r   <= hmnm_pkg::HEIGHT_RST;
      strength_r <= hmnm_pkg::STRENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hmnm_pkg::CFG_WIDTH:    width_r    <= cfg_data[10:0];
        hmnm_pkg::CFG_HEIGHT:   height_r   <= cfg_data;
        hmnm_pkg::CFG_STRENGTH: strength_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hmnm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_height_value (in_height_value),
    .in_full         (in_full),
    .image_width     (width_r),
    .image_height    (height_r),
    .job_full        (jq_full),
    .job_push        (jq_push),
    .job_data        (front_job)
  );

  // decouple classification from arithmetic
  hmnm_fifo #(.W(JOB_W), .DEPTH(hmnm_pkg::QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (front_job),
    .full  (jq_full),
    .pop   (jq_pop),
    .rdata (back_job),
    .empty (jq_empty)
  );

  hmnm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .bump_strength (strength_r),
    .job_empty     (jq_empty),
    .job_data      (back_job),
    .job_pop       (jq_pop),
    .res_full      (rq_full),
    .res_push      (rq_push),
    .res_data      (back_res)
  );

  // hold finished words until the reader pops them
  hmnm_fifo #(.W(RES_W), .DEPTH(hmnm_pkg::QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (back_res),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_blue_value  = out_res.blue;
  assign out_green_value = out_res.green;
  assign out_red_value   = out_res.red;
  assign out_last_in_run = out_res.last;
  assign out_frame_done  = out_res.frame_done;

endmodule

[src/hmnm_fifo.sv]
// Small synchronous queue of packed words.
// Used between front and back and on the result side. No dependencies.
`timescale 1ns / 1ps

module hmnm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= bump(wp_r);
      if (do_pop)  rp_r <= bump(rp_r);
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[src/hmnm_front.sv]
// Front end: takes heights, keeps the line store and counters, and turns
// each height into up to three normal jobs. Depends on hmnm_pkg.
`timescale 1ns / 1ps

module hmnm_front #(
  parameter int MAX_WIDTH = hmnm_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_height_value,
  output logic               in_full,
  input  logic [10:0]        image_width,
  input  logic [15:0]        image_height,
  input  logic               job_full,
  output logic               job_push,
  output hmnm_pkg::job_t     job_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (AW + 1 > 11) ? AW + 1 : 11;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [7:0]    prev_r;
  logic [7:0]    old_prev_r, pix_h_r, above_r, rdata_r;
  logic [AW-1:0] pix_col_r;
  logic          last_col_r;
  logic [2:0]    pend_r, pend_nxt;
  logic [7:0]    mem [MAX_WIDTH];

  logic [EW-1:0] w_ext, w_eff;
  logic [15:0]   h_eff;
  logic          last_col, last_row, accept;
  logic [AW-1:0] raddr, right_addr;
  logic [7:0]    right_h;

  always_comb begin
    w_ext = EW'(image_width);
    if (w_ext == '0) w_eff = EW'(1);
    else if (w_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else w_eff = w_ext;
    h_eff    = (image_height == '0) ? 16'd1 : image_height;
    last_col = (EW'(col_r) + EW'(1)) >= w_eff;
    last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, h_eff};
  end

  assign in_full = (state_r != ST_IDLE);
  assign accept  = in_push && !in_full;

  assign right_addr = last_col_r ? pix_col_r : pix_col_r + 1'b1;
  assign raddr      = (state_r == ST_IDLE) ? col_r : right_addr;
  assign right_h    = last_col_r ? above_r : rdata_r;

  // line store: read the above pixel on accept, then the above-right one
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) mem[pix_col_r] <= pix_h_r;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  // pick the oldest pending job
  always_comb begin
    job_data = '0;
    pend_nxt = pend_r;
    if (pend_r[0]) begin
      job_data.center = above_r;
      job_data.right  = right_h;
      job_data.below  = pix_h_r;
      pend_nxt[0]     = 1'b0;
    end else if (pend_r[1]) begin
      job_data.center = old_prev_r;
      job_data.right  = pix_h_r;
      job_data.below  = old_prev_r;
      pend_nxt[1]     = 1'b0;
    end else begin
      job_data.center     = pix_h_r;
      job_data.right      = pix_h_r;
      job_data.below      = pix_h_r;
      job_data.frame_done = 1'b1;
      pend_nxt[2]         = 1'b0;
    end
    job_data.last = (pend_nxt == '0);
  end

  assign job_push = (state_r == ST_EMIT) && (pend_r != '0) && !job_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (pend_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      prev_r  <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        prev_r <= in_height_value;
        pend_r <= {last_row && last_col, last_row && (col_r != '0), row_r != '0};
      end else if (job_push) begin
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_h_r    <= in_height_value;
      pix_col_r  <= col_r;
      last_col_r <= last_col;
      old_prev_r <= prev_r;
    end
    if (state_r == ST_RD) above_r <= rdata_r;
  end

endmodule

[src/hmnm_back.sv]
// Back end: turns one job into a blue/green/red word with a short
// multiply sequence and a seven step square-root search. Depends on hmnm_pkg.
`timescale 1ns / 1ps

module hmnm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    bump_strength,
  input  logic           job_empty,
  input  hmnm_pkg::job_t job_data,
  output logic           job_pop,
  input  logic           res_full,
  output logic           res_push,
  output hmnm_pkg::res_t res_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_MUL3 = 3'd3;
  localparam logic [2:0] ST_ITER = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  ad_r, ae_r;
  logic        neg_d_r, neg_e_r, last_r, fd_r;
  logic [31:0] ss_r;
  logic [15:0] sum_r;
  logic [23:0] px_r, py_r;
  logic [47:0] q_r;
  logic [30:0] nx_r, ny_r;
  logic [2:0]  bit_r;
  // lane 0: z, lane 1: y, lane 2: x
  logic [63:0] nn_r [3];
  logic [63:0] acc_r [3];
  logic [6:0]  k_r [3];
  logic [63:0] acc_nxt [3];
  logic [6:0]  k_nxt [3];

  logic [7:0]  dw, ew;

  assign dw      = job_data.right - job_data.center;
  assign ew      = job_data.below - job_data.center;
  assign job_pop = (state_r == ST_IDLE) && !job_empty;

  // one trial bit per lane: (k + b)^2 Q = k^2 Q + (2k + b) b Q
  always_comb begin
    logic [7:0]  t2;
    logic [55:0] prod;
    logic [63:0] cand;
    for (int i = 0; i < 3; i++) begin
      t2   = {k_r[i], 1'b0} + (8'd1 << bit_r);
      prod = 56'(t2) * 56'(q_r);
      cand = acc_r[i] + (64'(prod) << bit_r);
      if (cand <= nn_r[i]) begin
        acc_nxt[i] = cand;
        k_nxt[i]   = k_r[i] | (7'd1 << bit_r);
      end else begin
        acc_nxt[i] = acc_r[i];
        k_nxt[i]   = k_r[i];
      end
    end
  end

  always_comb begin
    res_data.blue       = 8'd128 + {1'b0, k_r[0]};
    res_data.green      = neg_e_r ? 8'd128 + {1'b0, k_r[1]} : 8'd128 - {1'b0, k_r[1]};
    res_data.red        = neg_d_r ? 8'd128 + {1'b0, k_r[2]} : 8'd128 - {1'b0, k_r[2]};
    res_data.last       = last_r;
    res_data.frame_done = fd_r;
  end

  assign res_push = (state_r == ST_OUT) && !res_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (job_pop) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_ITER;
      ST_ITER: if (bit_r == '0) state_nxt = ST_OUT;
      ST_OUT:  if (res_push) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        neg_d_r <= dw[7];
        neg_e_r <= ew[7];
        ad_r    <= dw[7] ? ~dw + 1'b1 : dw;
        ae_r    <= ew[7] ? ~ew + 1'b1 : ew;
        last_r  <= job_data.last;
        fd_r    <= job_data.frame_done;
      end
      ST_MUL1: begin
        ss_r  <= {16'b0, bump_strength} * {16'b0, bump_strength};
        sum_r <= {8'b0, ad_r} * {8'b0, ad_r} + {8'b0, ae_r} * {8'b0, ae_r};
        px_r  <= {8'b0, bump_strength} * {16'b0, ad_r};
        py_r  <= {8'b0, bump_strength} * {16'b0, ae_r};
      end
      ST_MUL2: begin
        q_r  <= {16'b0, ss_r} * {32'b0, sum_r} + hmnm_pkg::Q_BIAS;
        nx_r <= {px_r, 7'b0} - {7'b0, px_r};
        ny_r <= {py_r, 7'b0} - {7'b0, py_r};
      end
      ST_MUL3: begin
        nn_r[0] <= hmnm_pkg::Z_NUM_SQ;
        nn_r[1] <= {33'b0, ny_r} * {33'b0, ny_r};
        nn_r[2] <= {33'b0, nx_r} * {33'b0, nx_r};
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= '0;
          k_r[i]   <= '0;
        end
        bit_r <= 3'd6;
      end
      ST_ITER: begin
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= acc_nxt[i];
          k_r[i]   <= k_nxt[i];
        end
        bit_r <= bit_r - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[src/hmnm_checker.sv]
// Port-level checks for the height map to normal map block.
// Bound to heightmap_to_normal_map; no package dependency.
`timescale 1ns / 1ps

module hmnm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_blue_value,
  input logic [7:0] out_red_value,
  input logic       out_last_in_run,
  input logic       out_frame_done
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_done) |-> out_last_in_run)
    else $error("frame end word not last of its run");

  a_blue_upper: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_blue_value[7])
    else $error("blue below 128");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_red_value))
    else $error("waiting word changed");

endmodule

bind heightmap_to_normal_map hmnm_checker u_chk (.*);
